// ----- rtl/hk_pkg.sv -----
// Shared types, constants and key tables for the Hangul keystroke block.
`default_nettype none

package hk_pkg;

    localparam int CODE_W      = 16;
    localparam int KEY_W       = 8;
    localparam int MAX_KEYS    = 5;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CODE_W-1:0] LATIN_LIMIT = 16'd256;
    localparam logic [CODE_W-1:0] SYL_BASE    = 16'hAC00;
    localparam logic [CODE_W-1:0] SYL_LAST    = 16'hD7A3;
    localparam logic [CODE_W-1:0] CONS_FIRST  = 16'h3131;
    localparam logic [CODE_W-1:0] CONS_LAST   = 16'h314E;
    localparam logic [CODE_W-1:0] VOW_FIRST   = 16'h314F;
    localparam logic [CODE_W-1:0] VOW_LAST    = 16'h3163;

    localparam int INITIALS = 19;
    localparam int MEDIALS  = 21;
    localparam int FINALS   = 28;
    localparam int CONS_N   = 30;

    // Syllable offset s < 11172: s / 588 and s / 28 by reciprocal multiply.
    localparam int SYL_W      = 14;
    localparam int IDX_W      = 5;
    localparam int Q28_W      = 9;
    localparam int INI_RECIP  = 28533;
    localparam int INI_SHIFT  = 24;
    localparam int INI_RW     = 15;
    localparam int Q28_RECIP  = 9363;
    localparam int Q28_SHIFT  = 18;
    localparam int Q28_RW     = 14;

    typedef enum logic [2:0] {
        KIND_LATIN,
        KIND_SYL,
        KIND_CONS,
        KIND_VOWEL,
        KIND_ERR
    } kind_t;

    typedef struct packed {
        logic [MAX_KEYS-1:0][KEY_W-1:0] keys;
        logic [CNT_W-1:0]               count;
        logic                           err;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [KEY_W-1:0] INIT_KEY [INITIALS] = '{
        "r","R","s","e","E","f","a","q","Q","t","T","d","w","W","c","z","x","v","g"
    };
    localparam logic [KEY_W-1:0] VOW_KEY_A [MEDIALS] = '{
        "k","o","i","O","j","p","u","P","h","h","h","h","y","n","n","n","n","b","m","m","l"
    };
    localparam logic [KEY_W-1:0] VOW_KEY_B [MEDIALS] = '{
        "k","o","i","O","j","p","u","P","h","k","o","l","y","n","j","p","l","b","m","l","l"
    };
    localparam logic [KEY_W-1:0] FIN_KEY_A [FINALS] = '{
        8'd0,"r","R","r","s","s","s","e","f","f","f","f","f","f","f","f",
        "a","q","q","t","T","d","w","c","z","x","v","g"
    };
    localparam logic [KEY_W-1:0] FIN_KEY_B [FINALS] = '{
        8'd0,"r","R","t","s","w","g","e","f","r","a","q","t","x","v","g",
        "a","q","t","t","T","d","w","c","z","x","v","g"
    };
    // Zero marks a compound consonant that is not an initial.
    localparam logic [KEY_W-1:0] CONS_KEY [CONS_N] = '{
        "r","R",8'd0,"s",8'd0,8'd0,"e","E","f",8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
        "a","q","Q",8'd0,"t","T","d","w","W","c","z","x","v","g"
    };

    function automatic logic [KEY_W-1:0] init_key(input logic [IDX_W-1:0] i);
        init_key = (int'(i) < INITIALS) ? INIT_KEY[i] : '0;
    endfunction

    function automatic logic [KEY_W-1:0] vow_key_a(input logic [IDX_W-1:0] i);
        vow_key_a = (int'(i) < MEDIALS) ? VOW_KEY_A[i] : '0;
    endfunction

    function automatic logic [KEY_W-1:0] vow_key_b(input logic [IDX_W-1:0] i);
        vow_key_b = (int'(i) < MEDIALS) ? VOW_KEY_B[i] : '0;
    endfunction

    function automatic logic [KEY_W-1:0] fin_key_a(input logic [IDX_W-1:0] i);
        fin_key_a = (int'(i) < FINALS) ? FIN_KEY_A[i] : '0;
    endfunction

    function automatic logic [KEY_W-1:0] fin_key_b(input logic [IDX_W-1:0] i);
        fin_key_b = (int'(i) < FINALS) ? FIN_KEY_B[i] : '0;
    endfunction

    function automatic logic [KEY_W-1:0] cons_key(input logic [IDX_W-1:0] i);
        cons_key = (int'(i) < CONS_N) ? CONS_KEY[i] : '0;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hk_if.sv -----
// Valid/ready channel interfaces for characters in and keys out.
`default_nettype none

interface hk_char_if import hk_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

interface hk_key_if import hk_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_char;
    logic             last;
    logic             error;

    modport source (output valid, output key_char, output last, output error, input ready);
    modport sink   (input valid, input key_char, input last, input error, output ready);
endinterface

`default_nettype wire

// ----- rtl/hk_front.sv -----
// Front end: accepts characters, classifies and decomposes them into key runs.
`default_nettype none

module hk_front import hk_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hk_char_if.sink     chars,
    input  q_stat_t     qstat,
    output logic        push,
    output cmd_t        cmd
);

    // stage A
    logic              a_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              a_ready;

    // stage B
    logic              b_valid_reg;
    logic              b_ready;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [KEY_W-1:0]  byte_reg;
    logic [KEY_W-1:0]  cons_key_reg;
    logic [KEY_W-1:0]  cons_key_next;
    logic [IDX_W-1:0]  jidx_reg;
    logic [IDX_W-1:0]  jidx_next;
    logic [IDX_W-1:0]  ini_reg;
    logic [IDX_W-1:0]  ini_next;
    logic [Q28_W-1:0]  q28_reg;
    logic [Q28_W-1:0]  q28_next;
    logic [IDX_W-1:0]  s_low_reg;

    logic [SYL_W-1:0]          syl_off;
    logic [SYL_W+INI_RW-1:0]   ini_prod;
    logic [SYL_W+Q28_RW-1:0]   q28_prod;
    logic [IDX_W-1:0]          cons_idx;

    logic [Q28_W-1:0]  med_wide;
    logic [IDX_W-1:0]  med;
    logic [Q28_W-1:0]  fin_sub;
    logic [IDX_W-1:0]  fin;
    logic [IDX_W-1:0]  vidx;
    logic [KEY_W-1:0]  va;
    logic [KEY_W-1:0]  vb;
    logic [KEY_W-1:0]  fa;
    logic [KEY_W-1:0]  fb;
    logic [CNT_W-1:0]  n;

    assign b_ready     = !b_valid_reg || !qstat.full;
    assign a_ready     = !a_valid_reg || b_ready;
    assign chars.ready = a_ready;
    assign push        = b_valid_reg && !qstat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= chars.valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && chars.valid)
            code_reg <= chars.code_unit;
        if (b_ready && a_valid_reg)
        begin
            kind_reg     <= kind_next;
            byte_reg     <= code_reg[KEY_W-1:0];
            cons_key_reg <= cons_key_next;
            jidx_reg     <= jidx_next;
            ini_reg      <= ini_next;
            q28_reg      <= q28_next;
            s_low_reg    <= syl_off[IDX_W-1:0];
        end
    end

    // Stage A: classify and take the syllable offset apart.
    assign syl_off  = SYL_W'(code_reg - SYL_BASE);
    assign ini_prod = SYL_W'(syl_off) * INI_RW'(INI_RECIP);
    assign q28_prod = SYL_W'(syl_off) * Q28_RW'(Q28_RECIP);
    assign ini_next = ini_prod[INI_SHIFT +: IDX_W];
    assign q28_next = q28_prod[Q28_SHIFT +: Q28_W];
    assign cons_idx = IDX_W'(code_reg - CONS_FIRST);

    always_comb
    begin
        cons_key_next = cons_key(cons_idx);
        jidx_next     = IDX_W'(code_reg - VOW_FIRST);
        if (code_reg < LATIN_LIMIT)
            kind_next = KIND_LATIN;
        else if (code_reg >= SYL_BASE && code_reg <= SYL_LAST)
            kind_next = KIND_SYL;
        else if (code_reg >= CONS_FIRST && code_reg <= CONS_LAST && cons_key_next != '0)
            kind_next = KIND_CONS;
        else if (code_reg >= VOW_FIRST && code_reg <= VOW_LAST)
            kind_next = KIND_VOWEL;
        else
            kind_next = KIND_ERR;
    end

    // Stage B: medial = s/28 - 21*initial, final = s - 28*(s/28).
    assign med_wide = q28_reg - Q28_W'(ini_reg) * Q28_W'(5'd21);
    assign med      = med_wide[IDX_W-1:0];
    assign fin_sub  = Q28_W'(q28_reg * 5'd28);
    assign fin      = IDX_W'(s_low_reg - fin_sub[IDX_W-1:0]);
    assign vidx     = (kind_reg == KIND_SYL) ? med : jidx_reg;
    assign va       = vow_key_a(vidx);
    assign vb       = vow_key_b(vidx);
    assign fa       = fin_key_a(fin);
    assign fb       = fin_key_b(fin);

    always_comb
    begin
        cmd = '0;
        n   = '0;
        case (kind_reg)
            KIND_LATIN:
            begin
                cmd.keys[0] = byte_reg;
                n           = CNT_W'(1);
            end
            KIND_CONS:
            begin
                cmd.keys[0] = cons_key_reg;
                n           = CNT_W'(1);
            end
            KIND_SYL, KIND_VOWEL:
            begin
                if (kind_reg == KIND_SYL)
                begin
                    cmd.keys[n] = init_key(ini_reg);
                    n           = n + 1'b1;
                end
                cmd.keys[n] = va;
                n           = n + 1'b1;
                if (va != vb)
                begin
                    cmd.keys[n] = vb;
                    n           = n + 1'b1;
                end
                if (kind_reg == KIND_SYL && fin != '0)
                begin
                    cmd.keys[n] = fa;
                    n           = n + 1'b1;
                    if (fa != fb)
                    begin
                        cmd.keys[n] = fb;
                        n           = n + 1'b1;
                    end
                end
            end
            default:
            begin
                cmd.err = 1'b1;
                n       = CNT_W'(1);
            end
        endcase
        cmd.count = n;
    end

endmodule

`default_nettype wire

// ----- rtl/hk_queue.sv -----
// Command queue between the front end and the key emitter.
`default_nettype none

module hk_queue import hk_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      wdata,
    input  wire logic pop,
    output cmd_t      rdata,
    output q_stat_t   stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign rdata      = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hk_back.sv -----
// Back end: walks each queued key run and emits one key per transfer.
`default_nettype none

module hk_back import hk_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  q_stat_t   qstat,
    input  cmd_t      head,
    output logic      pop,
    hk_key_if.source  keys
);

    logic [CNT_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic             last_reg;
    logic             err_reg;
    logic             load;
    logic             at_last;

    assign load    = !qstat.empty && (!out_valid_reg || keys.ready);
    assign at_last = (idx_reg == CNT_W'(head.count - 1'b1));
    assign pop     = load && at_last;

    assign keys.valid    = out_valid_reg;
    assign keys.key_char = key_reg;
    assign keys.last     = last_reg;
    assign keys.error    = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= at_last ? '0 : idx_reg + 1'b1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (keys.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the payload while the sink stalls.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg  <= head.keys[idx_reg];
            last_reg <= at_last;
            err_reg  <= head.err;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hangul_to_keystrokes.sv -----
// Path: a character passes the stage A and B registers and the command queue,
// then its first key is registered at the output. Throughput: one key per cycle
// when the queue holds a run and the sink is ready; a run of 1 to 5 keys goes out
// key by key; a new character enters every cycle while the queue has room.
// Reset: rst_n clears the pipeline valids, queue pointers and key index; no
// clearing pass is needed.
`default_nettype none

module hangul_to_keystrokes import hk_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hk_char_if.sink   chars,
    hk_key_if.source  keys
);

    logic    push;
    logic    pop;
    cmd_t    cmd;
    cmd_t    head;
    q_stat_t qstat;

    hk_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .qstat (qstat),
        .push  (push),
        .cmd   (cmd)
    );

    hk_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd),
        .pop   (pop),
        .rdata (head),
        .stat  (qstat)
    );

    hk_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qstat (qstat),
        .head  (head),
        .pop   (pop),
        .keys  (keys)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("command pushed into a full queue");

    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cmd.count != '0 && cmd.count <= CNT_W'(MAX_KEYS)))
        else $error("key run length out of range");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (keys.valid && keys.error) |-> (keys.key_char == '0 && keys.last))
        else $error("error result not a single zero key");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (keys.valid && keys.last))
        else $error("run retired without a final key");

endmodule

`default_nettype wire
